[hdl/i2c_master_byte_sequencer_defines.svh]
// ---------------------------------------------------------------------------
// I2C master byte sequencer: assertion macros
// Concurrent check macros used by the sequencer; empty when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define I2CM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2cm: same-cycle check failed");
`define I2CM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2cm: next-cycle check failed");
`else
`define I2CM_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[hdl/i2cm_pkg.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer: shared package
// Types, register indexes, command codes and reset values.
// ---------------------------------------------------------------------------
package i2cm_pkg;

	localparam int CHAIN_DEPTH = 3;

	localparam logic [1:0] REG_GUARD   = 2'd0;
	localparam logic [1:0] REG_WRPHASE = 2'd1;
	localparam logic [1:0] REG_RDPHASE = 2'd2;
	localparam logic [1:0] REG_ACKTO   = 2'd3;

	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_STOP  = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_READ  = 3'd3;
	localparam logic [2:0] ACT_CHECK = 3'd4;
	localparam logic [2:0] ACT_NOACK = 3'd5;
	localparam logic [2:0] ACT_MACK  = 3'd6;
	localparam logic [2:0] ACT_RSVD  = 3'd7;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ST_A    = 4'd1,
		PH_ST_B    = 4'd2,
		PH_SP_A    = 4'd3,
		PH_SP_B    = 4'd4,
		PH_WR_BIT  = 4'd5,
		PH_WR_HI   = 4'd6,
		PH_WR_LO   = 4'd7,
		PH_RD_HI   = 4'd8,
		PH_RD_LO   = 4'd9,
		PH_CK_HI   = 4'd10,
		PH_CK_POLL = 4'd11,
		PH_NK_HI   = 4'd12,
		PH_AK_LO   = 4'd13,
		PH_END     = 4'd14
	} phase_t;

	typedef struct packed {
		logic [7:0] guard;
		logic [7:0] wr_phase;
		logic [7:0] rd_phase;
		logic [7:0] ack_to;
	} cfg_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] action;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] tick;
		logic [3:0] bits;
		logic [7:0] shift;
		logic       ack;
		logic       scl;
		logic       sda;
		logic       en;
		logic [7:0] rd;
		logic [7:0] ack_left;
	} st_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       en;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       ack_missing;
	} res_t;

	localparam cfg_t CFG_RESET = '{guard: 8'd3, wr_phase: 8'd1, rd_phase: 8'd2, ack_to: 8'd10};

	localparam st_t ST_RESET = '{
		phase: PH_IDLE, tick: 8'd0, bits: 4'd0, shift: 8'd0, ack: 1'b0,
		scl: 1'b1, sda: 1'b1, en: 1'b1, rd: 8'd0, ack_left: 8'd0
	};

endpackage

[hdl/i2c_master_byte_sequencer.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer: top level
// Bit-banged I2C master stepped by one timing tick per input item.
// ---------------------------------------------------------------------------
// Each input item is one timing tick carrying the sampled SDA level and an
// optional command; each item yields exactly one result item with the line
// levels, busy, a done pulse, the last byte read and the ack-missing flag.
// The block takes one item per clock while the result is not stalled: the item is
// registered, and the sequencer state register is updated when the result slot is
// free and drives the result directly, so a result item is valid once the state
// register has taken its input item. A stalled result holds the input register,
// which then holds off the input. Zero-length waits let several line actions, up to
// a whole byte, complete within the same tick. Configuration writes are expected
// only while the sequencer is idle and no item is in flight.
module i2c_master_byte_sequencer import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] write_data, [8] sda_in, [15:9] zero
	input  logic [3:0]  s_axis_tuser,  // [0] cmd_valid, [3:1] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [0] scl_out, [1] sda_out, [2] sda_enable,
	                                   // [3] busy_res, [4] done_res, [12:5] read_byte,
	                                   // [13] ack_missing, [15:14] zero
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

`include "i2c_master_byte_sequencer_defines.svh"

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  m_valid_q;
	logic  step_en;
	res_t  res;

	assign step_en       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GUARD:   cfg_q.guard    <= cfg_data;
				REG_WRPHASE: cfg_q.wr_phase <= cfg_data;
				REG_RDPHASE: cfg_q.rd_phase <= cfg_data;
				REG_ACKTO:   cfg_q.ack_to   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (step_en) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= '{
				cmd_valid: s_axis_tuser[0], action: s_axis_tuser[3:1],
				write_data: s_axis_tdata[7:0], sda_in: s_axis_tdata[8]
			};
		end
	end

	i2cm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, res.ack_missing, res.rd, res.done, res.busy,
		res.en, res.sda, res.scl};

	`I2CM_ASSERT_IMP(a_done_idle, clk, arst_n, res.done, !res.busy)
	`I2CM_ASSERT_NXT(a_step_valid, clk, arst_n, step_en, m_valid_q)
	`I2CM_ASSERT_NXT(a_stall_hold, clk, arst_n, m_valid_q && !m_axis_tready, $stable(res))
	`I2CM_ASSERT_IMP(a_busy_cause, clk, arst_n, $rose(res.busy), $past(step_en))

endmodule

[hdl/i2cm_seq.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer: line sequencer
// Runs one tick per step: takes a command when idle, then performs up to CHAIN_DEPTH
// line actions whose waits have run out, then counts the tick down.
// ---------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step_en,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	st_t  st_q;
	st_t  st_d;
	logic done_q;
	logic done_d;

	function automatic st_t seq_step(st_t s, cfg_t c, logic sda_i);
		st_t        n;
		logic [3:0] nb;
		logic [7:0] sh;
		logic [7:0] al;
		n  = s;
		nb = s.bits + 4'd1;
		sh = {s.shift[6:0], sda_i};
		al = s.ack_left - ((s.ack_left != 8'd0) ? 8'd1 : 8'd0);
		unique case (s.phase)
			PH_ST_A: begin
				n.sda = 1'b0; n.phase = PH_ST_B; n.tick = c.guard;
			end
			PH_ST_B: begin
				n.scl = 1'b0; n.phase = PH_END; n.tick = c.guard;
			end
			PH_SP_A: begin
				n.sda = 1'b1; n.phase = PH_SP_B; n.tick = c.guard;
			end
			PH_SP_B: begin
				n.scl = 1'b1; n.phase = PH_END; n.tick = 8'd0;
			end
			PH_WR_BIT: begin
				if (c.wr_phase == 8'd0) begin
					// zero-length phases: whole byte goes out within this tick
					n.sda = s.shift[0]; n.scl = 1'b0; n.shift = 8'd0;
					n.bits = 4'd8; n.phase = PH_END; n.tick = 8'd0;
				end else begin
					n.sda = s.shift[7]; n.shift = {s.shift[6:0], 1'b0};
					n.phase = PH_WR_HI; n.tick = c.wr_phase;
				end
			end
			PH_WR_HI: begin
				n.scl = 1'b1; n.phase = PH_WR_LO; n.tick = c.wr_phase;
			end
			PH_WR_LO: begin
				n.scl = 1'b0; n.bits = nb;
				n.phase = nb[3] ? PH_END : PH_WR_BIT; n.tick = c.wr_phase;
			end
			PH_RD_HI: begin
				if (c.rd_phase == 8'd0) begin
					// zero-length phases: all eight samples see the same level
					n.shift = {8{sda_i}}; n.rd = {8{sda_i}}; n.scl = 1'b0;
					n.bits = 4'd8; n.phase = PH_END; n.tick = 8'd0;
				end else begin
					n.scl = 1'b1; n.phase = PH_RD_LO; n.tick = c.rd_phase;
				end
			end
			PH_RD_LO: begin
				n.shift = sh; n.scl = 1'b0; n.bits = nb; n.tick = c.rd_phase;
				if (nb[3]) begin
					n.rd = sh; n.phase = PH_END;
				end else begin
					n.phase = PH_RD_HI;
				end
			end
			PH_CK_HI: begin
				n.scl = 1'b1; n.ack_left = c.ack_to; n.phase = PH_CK_POLL; n.tick = 8'd1;
			end
			PH_CK_POLL: begin
				n.ack_left = al;
				if (al != 8'd0 && sda_i) begin
					n.phase = PH_CK_POLL; n.tick = 8'd1;
				end else begin
					n.ack = sda_i; n.scl = 1'b0; n.phase = PH_END; n.tick = c.guard;
				end
			end
			PH_NK_HI: begin
				n.scl = 1'b1; n.phase = PH_AK_LO; n.tick = c.guard;
			end
			PH_AK_LO: begin
				n.scl = 1'b0; n.phase = PH_END; n.tick = c.guard;
			end
			default: begin
				n.phase = PH_IDLE; n.tick = 8'd0;
			end
		endcase
		return n;
	endfunction

	always_comb begin
		st_t cur;
		cur    = st_q;
		done_d = 1'b0;
		if (st_q.phase == PH_IDLE && item.cmd_valid) begin
			unique case (item.action)
				ACT_START: begin
					cur.en = 1'b1; cur.sda = 1'b1; cur.scl = 1'b1;
					cur.phase = PH_ST_A; cur.tick = cfg.guard;
				end
				ACT_STOP: begin
					cur.scl = 1'b0; cur.en = 1'b1; cur.sda = 1'b0;
					cur.phase = PH_SP_A; cur.tick = cfg.guard;
				end
				ACT_WRITE: begin
					cur.en = 1'b1; cur.shift = item.write_data; cur.bits = 4'd0;
					cur.phase = PH_WR_BIT; cur.tick = cfg.guard;
				end
				ACT_READ: begin
					cur.en = 1'b0; cur.sda = 1'b1; cur.shift = 8'd0; cur.bits = 4'd0;
					cur.phase = PH_RD_HI; cur.tick = cfg.guard;
				end
				ACT_CHECK: begin
					cur.en = 1'b0; cur.sda = 1'b1;
					cur.phase = PH_CK_HI; cur.tick = cfg.guard;
				end
				ACT_NOACK: begin
					cur.en = 1'b0; cur.sda = 1'b1;
					cur.phase = PH_NK_HI; cur.tick = cfg.guard;
				end
				ACT_MACK: begin
					cur.en = 1'b1; cur.sda = 1'b0;
					cur.phase = PH_NK_HI; cur.tick = cfg.guard;
				end
				default: begin
				end
			endcase
		end
		for (int k = 0; k < CHAIN_DEPTH; k++) begin
			if (cur.phase != PH_IDLE && cur.tick == 8'd0) begin
				if (cur.phase == PH_END) begin
					done_d = 1'b1;
				end
				cur = seq_step(cur, cfg, item.sda_in);
			end
		end
		if (cur.tick != 8'd0) begin
			cur.tick = cur.tick - 8'd1;
		end
		st_d = cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_RESET;
			done_q <= 1'b0;
		end else if (step_en) begin
			st_q   <= st_d;
			done_q <= done_d;
		end
	end

	assign res = '{
		scl: st_q.scl, sda: st_q.sda, en: st_q.en,
		busy: (st_q.phase != PH_IDLE), done: done_q,
		rd: st_q.rd, ack_missing: st_q.ack
	};

endmodule

[tb/tb.sv]
// ---------------------------------------------------------------------------
// I2C master byte sequencer: testbench
// Streams timing ticks into the sequencer through a queue-fed driver, predicts
// the line levels, busy, done, read byte and ack flag of every tick, and
// compares each result item field by field. Timing registers are rewritten
// between phases with the block idle; sender gaps and receiver stalls vary.
// ---------------------------------------------------------------------------
module tb;
	import i2cm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [7:0] write_data, [8] sda_in
	logic [3:0]  s_axis_tuser = '0;  // [0] cmd_valid, [3:1] action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // [0] scl, [1] sda, [2] en, [3] busy, [4] done,
	                                 // [12:5] read_byte, [13] ack_missing
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_GUARD;
	logic [7:0]  cfg_data = '0;

	item_t tick_q[$];
	res_t  levels_q[$];
	cfg_t  timing = CFG_RESET;
	st_t   line_st = ST_RESET;
	int    send_idle_pct = 0;
	int    stall_pct = 0;
	int    mismatches = 0;
	int    ticks_pushed = 0;
	logic  sda_wander = 1'b1;

	i2c_master_byte_sequencer u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// one tick of the sequencer: accept, run zero-length waits, count down
	function automatic res_t sequence_tick(logic valid, logic [2:0] act, logic [7:0] data,
			logic sda_bit);
		res_t r;
		logic fin;
		fin = 1'b0;
		if (line_st.phase == PH_IDLE && valid) begin
			case (act)
				ACT_START: begin
					line_st.en = 1'b1; line_st.sda = 1'b1; line_st.scl = 1'b1;
					line_st.phase = PH_ST_A; line_st.tick = timing.guard;
				end
				ACT_STOP: begin
					line_st.scl = 1'b0; line_st.en = 1'b1; line_st.sda = 1'b0;
					line_st.phase = PH_SP_A; line_st.tick = timing.guard;
				end
				ACT_WRITE: begin
					line_st.en = 1'b1; line_st.shift = data; line_st.bits = '0;
					line_st.phase = PH_WR_BIT; line_st.tick = timing.guard;
				end
				ACT_READ: begin
					line_st.en = 1'b0; line_st.sda = 1'b1; line_st.shift = '0; line_st.bits = '0;
					line_st.phase = PH_RD_HI; line_st.tick = timing.guard;
				end
				ACT_CHECK: begin
					line_st.en = 1'b0; line_st.sda = 1'b1;
					line_st.phase = PH_CK_HI; line_st.tick = timing.guard;
				end
				ACT_NOACK: begin
					line_st.en = 1'b0; line_st.sda = 1'b1;
					line_st.phase = PH_NK_HI; line_st.tick = timing.guard;
				end
				ACT_MACK: begin
					line_st.en = 1'b1; line_st.sda = 1'b0;
					line_st.phase = PH_NK_HI; line_st.tick = timing.guard;
				end
				default: ;
			endcase
		end
		while (line_st.phase != PH_IDLE && line_st.tick == 8'd0) begin
			case (line_st.phase)
				PH_ST_A: begin
					line_st.sda = 1'b0; line_st.phase = PH_ST_B; line_st.tick = timing.guard;
				end
				PH_ST_B: begin
					line_st.scl = 1'b0; line_st.phase = PH_END; line_st.tick = timing.guard;
				end
				PH_SP_A: begin
					line_st.sda = 1'b1; line_st.phase = PH_SP_B; line_st.tick = timing.guard;
				end
				PH_SP_B: begin
					line_st.scl = 1'b1; line_st.phase = PH_END; line_st.tick = 8'd0;
				end
				PH_WR_BIT: begin
					line_st.sda = line_st.shift[7];
					line_st.shift = line_st.shift << 1;
					line_st.phase = PH_WR_HI; line_st.tick = timing.wr_phase;
				end
				PH_WR_HI: begin
					line_st.scl = 1'b1; line_st.phase = PH_WR_LO; line_st.tick = timing.wr_phase;
				end
				PH_WR_LO: begin
					line_st.scl = 1'b0;
					line_st.bits = line_st.bits + 4'd1;
					line_st.phase = (line_st.bits >= 4'd8) ? PH_END : PH_WR_BIT;
					line_st.tick = timing.wr_phase;
				end
				PH_RD_HI: begin
					line_st.scl = 1'b1; line_st.phase = PH_RD_LO; line_st.tick = timing.rd_phase;
				end
				PH_RD_LO: begin
					line_st.shift = {line_st.shift[6:0], sda_bit};
					line_st.scl = 1'b0;
					line_st.bits = line_st.bits + 4'd1;
					line_st.tick = timing.rd_phase;
					if (line_st.bits >= 4'd8) begin
						line_st.rd = line_st.shift;
						line_st.phase = PH_END;
					end else begin
						line_st.phase = PH_RD_HI;
					end
				end
				PH_CK_HI: begin
					line_st.scl = 1'b1;
					line_st.ack_left = timing.ack_to;
					line_st.phase = PH_CK_POLL; line_st.tick = 8'd1;
				end
				PH_CK_POLL: begin
					if (line_st.ack_left != 8'd0)
						line_st.ack_left = line_st.ack_left - 8'd1;
					if (line_st.ack_left != 8'd0 && sda_bit) begin
						line_st.tick = 8'd1;
					end else begin
						line_st.ack = sda_bit;
						line_st.scl = 1'b0;
						line_st.phase = PH_END; line_st.tick = timing.guard;
					end
				end
				PH_NK_HI: begin
					line_st.scl = 1'b1; line_st.phase = PH_AK_LO; line_st.tick = timing.guard;
				end
				PH_AK_LO: begin
					line_st.scl = 1'b0; line_st.phase = PH_END; line_st.tick = timing.guard;
				end
				default: begin
					line_st.phase = PH_IDLE; line_st.tick = 8'd0; fin = 1'b1;
				end
			endcase
		end
		if (line_st.tick != 8'd0)
			line_st.tick = line_st.tick - 8'd1;
		r.scl = line_st.scl;
		r.sda = line_st.sda;
		r.en = line_st.en;
		r.busy = (line_st.phase != PH_IDLE);
		r.done = fin;
		r.rd = line_st.rd;
		r.ack_missing = line_st.ack;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				levels_q.push_back(sequence_tick(s_axis_tuser[0], s_axis_tuser[3:1],
					s_axis_tdata[7:0], s_axis_tdata[8]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = tick_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {7'd0, nxt.sda_in, nxt.write_data};
					s_axis_tuser <= {nxt.action, nxt.cmd_valid};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (levels_q.size() == 0) begin
				$error("result item with nothing expected: %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = levels_q.pop_front();
				check_field("scl_out", int'(want.scl), int'(m_axis_tdata[0]));
				check_field("sda_out", int'(want.sda), int'(m_axis_tdata[1]));
				check_field("sda_enable", int'(want.en), int'(m_axis_tdata[2]));
				check_field("busy_res", int'(want.busy), int'(m_axis_tdata[3]));
				check_field("done_res", int'(want.done), int'(m_axis_tdata[4]));
				check_field("read_byte", int'(want.rd), int'(m_axis_tdata[12:5]));
				check_field("ack_missing", int'(want.ack_missing), int'(m_axis_tdata[13]));
			end
		end
	end

	// 0 low, 1 high, 2 slowly wandering level
	function automatic logic sda_level(int mode);
		if (mode == 0)
			return 1'b0;
		if (mode == 1)
			return 1'b1;
		if ($urandom_range(0, 99) < 30)
			sda_wander = ~sda_wander;
		return sda_wander;
	endfunction

	task automatic push_tick(logic valid, logic [2:0] act, logic [7:0] data, logic sda_bit);
		item_t it;
		it.cmd_valid = valid;
		it.action = act;
		it.write_data = data;
		it.sda_in = sda_bit;
		tick_q.push_back(it);
		ticks_pushed++;
	endtask

	// wait for the pipe to empty; keep ticking while a command is still running
	task automatic settle(int mode);
		forever begin
			@(posedge clk);
			#1;
			if (tick_q.size() == 0 && !s_axis_tvalid && levels_q.size() == 0) begin
				if (line_st.phase == PH_IDLE)
					break;
				repeat (8)
					push_tick(1'b0, ACT_START, 8'h00, sda_level(mode));
			end
		end
	endtask

	task automatic run_cmd(logic [2:0] act, logic [7:0] data, int hi_ticks, int mode);
		push_tick(1'b1, act, data, 1'b1);
		repeat (hi_ticks)
			push_tick(1'b0, act, 8'h00, 1'b1);
		settle(mode);
	endtask

	task automatic check_ack();
		run_cmd(ACT_CHECK, 8'h00, $urandom_range(0, 15), $urandom_range(0, 2));
	endtask

	task automatic transaction();
		run_cmd(ACT_START, 8'($urandom), 0, 2);
		run_cmd(ACT_WRITE, 8'($urandom), 0, 2);
		check_ack();
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 1)) begin
				run_cmd(ACT_WRITE, 8'($urandom), 0, 2);
				check_ack();
			end else begin
				run_cmd(ACT_READ, 8'h00, 0, 2);
				run_cmd($urandom_range(0, 1) ? ACT_MACK : ACT_NOACK, 8'($urandom), 0, 2);
			end
		end
		run_cmd(ACT_STOP, 8'($urandom), 0, 2);
	endtask

	// commands at random ticks, many landing on a busy block
	task automatic noise_burst();
		logic [2:0] act;
		repeat ($urandom_range(20, 60)) begin
			act = ($urandom_range(0, 39) == 0) ? ACT_RSVD : 3'($urandom_range(0, 6));
			push_tick($urandom_range(0, 99) < 35, act, 8'($urandom), sda_level(2));
		end
	endtask

	task automatic random_phase(int n);
		int goal;
		goal = ticks_pushed + n;
		while (ticks_pushed < goal) begin
			if ($urandom_range(0, 2) != 0)
				transaction();
			else
				noise_burst();
		end
		settle(2);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing(cfg_t c);
		@(posedge clk);
		cfg_wr_en <= 1'b1; cfg_index <= REG_GUARD; cfg_data <= c.guard;
		@(posedge clk);
		cfg_index <= REG_WRPHASE; cfg_data <= c.wr_phase;
		@(posedge clk);
		cfg_index <= REG_RDPHASE; cfg_data <= c.rd_phase;
		@(posedge clk);
		cfg_index <= REG_ACKTO; cfg_data <= c.ack_to;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		timing = c;
	endtask

	task automatic set_pace(int sel);
		send_idle_pct = (sel == 1) ? 69 : (sel == 3) ? 37 : 0;
		stall_pct = (sel == 2) ? 69 : (sel == 3) ? 37 : 0;
	endtask

	function automatic cfg_t small_timing();
		cfg_t c;
		c.guard = 8'($urandom_range(0, 4));
		c.wr_phase = 8'($urandom_range(1, 3));
		c.rd_phase = 8'($urandom_range(1, 3));
		c.ack_to = 8'($urandom_range(1, 12));
		return c;
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset timing, directed
		set_pace(0);
		push_tick(1'b1, ACT_RSVD, 8'hFF, 1'b0);
		settle(2);
		run_cmd(ACT_START, 8'h00, 0, 2);
		run_cmd(ACT_WRITE, 8'h00, 0, 2);
		run_cmd(ACT_CHECK, 8'h00, 4, 0);
		run_cmd(ACT_WRITE, 8'hFF, 0, 2);
		run_cmd(ACT_CHECK, 8'h00, 40, 1);
		run_cmd(ACT_WRITE, 8'hA5, 0, 2);
		run_cmd(ACT_READ, 8'h00, 0, 0);
		run_cmd(ACT_MACK, 8'h00, 0, 2);
		run_cmd(ACT_READ, 8'h00, 0, 1);
		run_cmd(ACT_NOACK, 8'h00, 0, 2);
		run_cmd(ACT_READ, 8'h00, 0, 2);
		// second command lands while busy and must be dropped
		push_tick(1'b1, ACT_START, 8'h00, 1'b1);
		push_tick(1'b1, ACT_WRITE, 8'hFF, 1'b0);
		settle(2);
		run_cmd(ACT_STOP, 8'h00, 0, 2);
		repeat (4) @(posedge clk);

		// zero waits and a zero ack timeout
		write_timing('{guard: 8'd0, wr_phase: 8'd0, rd_phase: 8'd0, ack_to: 8'd0});
		set_pace(1);
		random_phase(200);

		write_timing('{guard: 8'd1, wr_phase: 8'd1, rd_phase: 8'd1, ack_to: 8'd1});
		set_pace(2);
		random_phase(150);

		// longest ack timeout
		write_timing('{guard: 8'd2, wr_phase: 8'd1, rd_phase: 8'd1, ack_to: 8'd255});
		set_pace(0);
		run_cmd(ACT_START, 8'h00, 0, 2);
		run_cmd(ACT_WRITE, 8'h5A, 0, 2);
		run_cmd(ACT_CHECK, 8'h00, 0, 1);
		run_cmd(ACT_STOP, 8'h00, 0, 2);
		repeat (4) @(posedge clk);

		for (int p = 0; p < 5; p++) begin
			write_timing(small_timing());
			set_pace((p + 3) % 4);
			random_phase(40);
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && levels_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
